FILE: sv/tlsc_pkg.sv
// Shared types and constants of the text line splitter and row counter.
package tlsc_pkg;

  localparam int RES_SLOTS = 4;
  localparam int CNT_W     = 32;

  // Result kinds
  localparam logic [1:0] KIND_CONTENT = 2'd0;
  localparam logic [1:0] KIND_LINE    = 2'd1;
  localparam logic [1:0] KIND_DONE    = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] REG_STRIP_BOM  = 2'd0;
  localparam logic [1:0] REG_SKIP_BLANK = 2'd1;
  localparam logic [1:0] REG_MAX_ROWS   = 2'd2;

  // Byte constants
  localparam logic [7:0] BOM_B0   = 8'hef;
  localparam logic [7:0] BOM_B1   = 8'hbb;
  localparam logic [7:0] BOM_B2   = 8'hbf;
  localparam logic [7:0] CHAR_LF  = 8'h0a;
  localparam logic [7:0] CHAR_CR  = 8'h0d;
  localparam logic [7:0] CHAR_SP  = 8'h20;

  // Progress through a leading byte order mark
  typedef enum logic [3:0] {
    PH_START = 4'b0001,
    PH_EF    = 4'b0010,
    PH_EFBB  = 4'b0100,
    PH_BODY  = 4'b1000
  } bom_phase_t;

  typedef struct packed {
    logic             strip_bom;
    logic             skip_blank;
    logic [CNT_W-1:0] max_rows;
  } cfg_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [7:0]       out_byte;
    logic             line_blank;
    logic [CNT_W-1:0] row_count;
  } result_t;

  // All results of one input word, slot 0 first
  typedef struct packed {
    logic [2:0]                  num;
    result_t [RES_SLOTS-1:0]     res;
  } run_t;

  function automatic result_t mk_res(logic [1:0] kind, logic [7:0] b, logic blank,
                                     logic [CNT_W-1:0] rows);
    result_t r;
    r.kind       = kind;
    r.out_byte   = b;
    r.line_blank = blank;
    r.row_count  = rows;
    return r;
  endfunction

endpackage

FILE: sv/tlsc_in_if.sv
// Input channel: one raw text byte or an end marker per word.
interface tlsc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       is_end;

  modport source (output valid, output in_byte, output is_end, input ready);
  modport sink   (input valid, input in_byte, input is_end, output ready);
endinterface

FILE: sv/tlsc_out_if.sv
// Result channel: content bytes, line ends and stream done words.
interface tlsc_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  out_byte;
  logic        line_blank;
  logic [31:0] row_count;
  logic        last_of_run;

  modport source (output valid, output kind, output out_byte, output line_blank,
                  output row_count, output last_of_run, input ready);
  modport sink   (input valid, input kind, input out_byte, input line_blank,
                  input row_count, input last_of_run, output ready);
endinterface

FILE: sv/tlsc_cfg_if.sv
// Configuration write channel: register index and write data.
interface tlsc_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: sv/tlsc_core.sv
// Stream state and the single-pass step logic that builds the results of one word.
module tlsc_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 accept,
  input  logic [7:0]           in_byte,
  input  logic                 is_end,
  input  tlsc_pkg::cfg_t       cfg,
  output tlsc_pkg::run_t       run
);

  tlsc_pkg::bom_phase_t          ph_r, ph_nxt;
  logic                          pcr_r, pcr_nxt;
  logic                          rs_r, rs_nxt;
  logic                          snb_r, snb_nxt;
  logic                          lim_r, lim_nxt;
  logic [tlsc_pkg::CNT_W-1:0]    rows_r, rows_nxt;
  logic                          lim;
  logic                          do_plain;
  logic                          do_line;

  always_comb begin
    ph_nxt   = ph_r;
    pcr_nxt  = pcr_r;
    rs_nxt   = rs_r;
    snb_nxt  = snb_r;
    lim_nxt  = lim_r;
    rows_nxt = rows_r;
    run      = '0;
    do_plain = 1'b0;
    do_line  = 1'b0;
    lim      = lim_r || (rows_r >= cfg.max_rows);

    if (accept) begin
      lim_nxt = lim;
      if (is_end) begin
        if (!lim) begin
          // Replay a partial mark, then close an open record
          if (ph_r == tlsc_pkg::PH_EF || ph_r == tlsc_pkg::PH_EFBB) begin
            run.res[run.num[1:0]] = tlsc_pkg::mk_res(tlsc_pkg::KIND_CONTENT,
                                      tlsc_pkg::BOM_B0, 1'b0, rows_nxt);
            run.num = run.num + 3'd1;
            rs_nxt  = 1'b1;
            snb_nxt = 1'b1;
          end
          if (ph_r == tlsc_pkg::PH_EFBB) begin
            run.res[run.num[1:0]] = tlsc_pkg::mk_res(tlsc_pkg::KIND_CONTENT,
                                      tlsc_pkg::BOM_B1, 1'b0, rows_nxt);
            run.num = run.num + 3'd1;
          end
          do_line = rs_nxt;
        end
      end else if (!lim) begin
        case (ph_r)
          tlsc_pkg::PH_START: begin
            if (cfg.strip_bom && in_byte == tlsc_pkg::BOM_B0) begin
              ph_nxt = tlsc_pkg::PH_EF;
            end else begin
              ph_nxt   = tlsc_pkg::PH_BODY;
              do_plain = 1'b1;
            end
          end
          tlsc_pkg::PH_EF: begin
            if (in_byte == tlsc_pkg::BOM_B1) begin
              ph_nxt = tlsc_pkg::PH_EFBB;
            end else begin
              run.res[0] = tlsc_pkg::mk_res(tlsc_pkg::KIND_CONTENT,
                             tlsc_pkg::BOM_B0, 1'b0, rows_r);
              run.num  = 3'd1;
              rs_nxt   = 1'b1;
              snb_nxt  = 1'b1;
              ph_nxt   = tlsc_pkg::PH_BODY;
              do_plain = 1'b1;
            end
          end
          tlsc_pkg::PH_EFBB: begin
            if (in_byte == tlsc_pkg::BOM_B2) begin
              ph_nxt = tlsc_pkg::PH_BODY;
            end else begin
              run.res[0] = tlsc_pkg::mk_res(tlsc_pkg::KIND_CONTENT,
                             tlsc_pkg::BOM_B0, 1'b0, rows_r);
              run.res[1] = tlsc_pkg::mk_res(tlsc_pkg::KIND_CONTENT,
                             tlsc_pkg::BOM_B1, 1'b0, rows_r);
              run.num  = 3'd2;
              rs_nxt   = 1'b1;
              snb_nxt  = 1'b1;
              ph_nxt   = tlsc_pkg::PH_BODY;
              do_plain = 1'b1;
            end
          end
          default: begin
            do_plain = 1'b1;
          end
        endcase

        if (do_plain) begin
          if (pcr_r && in_byte == tlsc_pkg::CHAR_LF) begin
            // drop the LF of a CRLF pair
            pcr_nxt = 1'b0;
          end else if (in_byte == tlsc_pkg::CHAR_CR) begin
            pcr_nxt = 1'b1;
            do_line = 1'b1;
          end else begin
            pcr_nxt = 1'b0;
            if (in_byte == tlsc_pkg::CHAR_LF) begin
              do_line = 1'b1;
            end else begin
              run.res[run.num[1:0]] = tlsc_pkg::mk_res(tlsc_pkg::KIND_CONTENT,
                                        in_byte, 1'b0, rows_r);
              run.num = run.num + 3'd1;
              rs_nxt  = 1'b1;
              if (in_byte > tlsc_pkg::CHAR_SP) begin
                snb_nxt = 1'b1;
              end
            end
          end
        end
      end

      // Line end; the count never overflows here since the limit is not reached
      if (do_line) begin
        if (!cfg.skip_blank || snb_nxt) begin
          rows_nxt = rows_r + tlsc_pkg::CNT_W'(1);
        end
        run.res[run.num[1:0]] = tlsc_pkg::mk_res(tlsc_pkg::KIND_LINE, 8'h00,
                                  !snb_nxt, rows_nxt);
        run.num = run.num + 3'd1;
        rs_nxt  = 1'b0;
        snb_nxt = 1'b0;
      end

      if (is_end) begin
        run.res[run.num[1:0]] = tlsc_pkg::mk_res(tlsc_pkg::KIND_DONE, 8'h00,
                                  1'b0, rows_nxt);
        run.num  = run.num + 3'd1;
        ph_nxt   = tlsc_pkg::PH_START;
        pcr_nxt  = 1'b0;
        rs_nxt   = 1'b0;
        snb_nxt  = 1'b0;
        rows_nxt = '0;
        lim_nxt  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r   <= tlsc_pkg::PH_START;
      pcr_r  <= 1'b0;
      rs_r   <= 1'b0;
      snb_r  <= 1'b0;
      lim_r  <= 1'b0;
      rows_r <= '0;
    end else begin
      ph_r   <= ph_nxt;
      pcr_r  <= pcr_nxt;
      rs_r   <= rs_nxt;
      snb_r  <= snb_nxt;
      lim_r  <= lim_nxt;
      rows_r <= rows_nxt;
    end
  end

endmodule

FILE: sv/tlsc_run_buf.sv
// Run buffer for the results of one word, drained into a registered output stage.
module tlsc_run_buf (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load,
  input  tlsc_pkg::run_t       run,
  output logic                 free,
  output logic                 out_valid,
  input  logic                 out_ready,
  output tlsc_pkg::result_t    out_res,
  output logic                 out_last
);

  tlsc_pkg::result_t [tlsc_pkg::RES_SLOTS-1:0] slots_r;
  logic [1:0]  idx_r, idx_nxt;
  logic [2:0]  rem_r, rem_nxt;
  logic        ov_r, ov_nxt;
  logic        pop;

  // Move the next slot forward when the output stage is empty or being taken
  assign pop  = (rem_r != 3'd0) && (!ov_r || out_ready);
  assign free = (rem_r == 3'd0) || (rem_r == 3'd1 && pop);

  always_comb begin
    idx_nxt = idx_r;
    rem_nxt = rem_r;
    if (pop) begin
      idx_nxt = idx_r + 2'd1;
      rem_nxt = rem_r - 3'd1;
    end
    if (load && run.num != 3'd0) begin
      idx_nxt = 2'd0;
      rem_nxt = run.num;
    end
    if (pop) begin
      ov_nxt = 1'b1;
    end else if (out_ready) begin
      ov_nxt = 1'b0;
    end else begin
      ov_nxt = ov_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= 2'd0;
      rem_r <= 3'd0;
      ov_r  <= 1'b0;
    end else begin
      idx_r <= idx_nxt;
      rem_r <= rem_nxt;
      ov_r  <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load && run.num != 3'd0) begin
      slots_r <= run.res;
    end
    if (pop) begin
      out_res  <= slots_r[idx_r];
      out_last <= (rem_r == 3'd1);
    end
  end

  assign out_valid = ov_r;

endmodule

FILE: sv/text_line_splitter_counter_top.sv
// Top level of the text line splitter and row counter.
//
// Usage:
//   in_ch  - one word per byte of text (in_byte), or an end marker (is_end set).
//   out_ch - result words: content byte, line end (with line_blank and the
//            running row_count) or stream done (with the final count).
//            last_of_run flags the final result caused by one input word.
//   cfg_ch - register writes (strip_bom, skip_blank, max_rows); always ready.
//            Write only while the block is idle.
// Flow: the results of a word are registered into the run buffer, then moved
//   into the output register. Throughput: one input word per cycle as long as
//   each word gives at most one result and out_ch does not stall; a word that
//   gives more results (mark replay, end of stream) drops in_ch.ready while the
//   run buffer drains. The step logic fills a four-slot run buffer in one pass;
//   it drains one result per cycle into the output register unless out_ch stalls.
// Reset (rst_n low at a clock edge) clears stream state, the run buffer and
//   the output stage, and sets the registers to their defaults (max_rows all
//   ones). When out_ch stalls, the output word holds and one further input
//   word with results is taken into the run buffer before in_ch drops ready.
module text_line_splitter_counter_top (
  input  logic       clk,
  input  logic       rst_n,
  tlsc_in_if.sink    in_ch,
  tlsc_out_if.source out_ch,
  tlsc_cfg_if.sink   cfg_ch
);

  tlsc_pkg::cfg_t     cfg_r;
  tlsc_pkg::run_t     run;
  tlsc_pkg::result_t  out_res;
  logic               accept;
  logic               free;
  logic               out_last;

  // Configuration registers: a write lands the cycle it is presented
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.strip_bom  <= 1'b0;
      cfg_r.skip_blank <= 1'b0;
      cfg_r.max_rows   <= '1;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        tlsc_pkg::REG_STRIP_BOM:  cfg_r.strip_bom  <= cfg_ch.data[0];
        tlsc_pkg::REG_SKIP_BLANK: cfg_r.skip_blank <= cfg_ch.data[0];
        tlsc_pkg::REG_MAX_ROWS:   cfg_r.max_rows   <= cfg_ch.data[tlsc_pkg::CNT_W-1:0];
        default: ;  // unused index: drop the write
      endcase
    end
  end

  // Take a word whenever the run buffer is free or frees this cycle
  assign in_ch.ready = free;
  assign accept      = in_ch.valid && free;

  tlsc_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .in_byte (in_ch.in_byte),
    .is_end  (in_ch.is_end),
    .cfg     (cfg_r),
    .run     (run)
  );

  tlsc_run_buf u_run_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (accept),
    .run       (run),
    .free      (free),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_res   (out_res),
    .out_last  (out_last)
  );

  // Unpack the output register onto the result channel
  assign out_ch.kind        = out_res.kind;
  assign out_ch.out_byte    = out_res.out_byte;
  assign out_ch.line_blank  = out_res.line_blank;
  assign out_ch.row_count   = out_res.row_count;
  assign out_ch.last_of_run = out_last;

endmodule

FILE: sv/tlsc_checker.sv
// Port-level checks on the result channel, bound to the top level.
module tlsc_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [1:0]  kind,
  input  logic [7:0]  out_byte,
  input  logic        line_blank,
  input  logic [31:0] row_count,
  input  logic        last_of_run
);

  // A stalled result word holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(out_byte) &&
      $stable(line_blank) && $stable(row_count) && $stable(last_of_run))
    else $error("stalled result word changed");

  // Stream done always closes the run of its end marker
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && kind == tlsc_pkg::KIND_DONE |-> last_of_run)
    else $error("done word not last of run");

  // Only line ends carry the blank flag; only content carries a byte
  a_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && kind != tlsc_pkg::KIND_CONTENT |-> out_byte == 8'h00 &&
      (kind == tlsc_pkg::KIND_LINE || !line_blank))
    else $error("field set for wrong kind");

  // The row count never drops within a stream
  a_rows: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && kind != tlsc_pkg::KIND_DONE ##1 out_valid |->
      row_count >= $past(row_count))
    else $error("row count went backward");

endmodule

bind text_line_splitter_counter_top tlsc_checker u_tlsc_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .kind        (out_ch.kind),
  .out_byte    (out_ch.out_byte),
  .line_blank  (out_ch.line_blank),
  .row_count   (out_ch.row_count),
  .last_of_run (out_ch.last_of_run)
);

FILE: tb/sv/text_line_splitter_counter_top_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench of the text line splitter and row counter top level.
module text_line_splitter_counter_top_tb;

  localparam int STALL_MAX     = 17;    // longest drawn per-word wait of either side
  localparam int HOLD_CYCLES   = 200;   // long receiver hold-off under pressure
  localparam int IDLE_LIMIT    = 2000;  // cycles with no handshake before giving up
  localparam int SETTLE_CYCLES = 6;     // pipeline is two deep; leave a margin
  localparam int PRESSURE_ITEMS = 30;

  // One result word as it should appear on out_ch
  typedef struct packed {
    tlsc_pkg::result_t res;
    logic              last;
  } line_word_t;

  logic clk;
  logic rst_n;

  tlsc_in_if  in_ch();
  tlsc_out_if out_ch();
  tlsc_cfg_if cfg_ch();

  text_line_splitter_counter_top dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  // Register copies, updated on each accepted configuration word
  logic                       cfg_strip_bom;
  logic                       cfg_skip_blank;
  logic [tlsc_pkg::CNT_W-1:0] cfg_max_rows;

  // Stream state of the splitter as seen from outside
  tlsc_pkg::bom_phase_t       mark_phase;
  logic                       after_cr;      // last separator was CR: swallow one LF
  logic                       in_record;     // content seen since the last line end
  logic                       line_has_ink;  // a byte above space seen in this line
  logic [tlsc_pkg::CNT_W-1:0] row_total;
  logic                       rows_capped;

  line_word_t awaited_words[$];    // results still owed by the block, oldest first

  int fail_count = 0;
  bit steady     = 1'b0;           // both sides run without idling
  bit hold_rx    = 1'b0;           // ask the receiver for one long hold-off

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Splitter prediction
  // ---------------------------------------------------------------------------

  function automatic void clear_stream();
    mark_phase   = tlsc_pkg::PH_START;
    after_cr     = 1'b0;
    in_record    = 1'b0;
    line_has_ink = 1'b0;
    row_total    = '0;
    rows_capped  = 1'b0;
  endfunction

  // Queue one result; row_count always carries the running total
  function automatic void add_word(logic [1:0] kind, logic [7:0] b, logic blank);
    line_word_t w;
    w.res.kind       = kind;
    w.res.out_byte   = b;
    w.res.line_blank = blank;
    w.res.row_count  = row_total;
    w.last           = 1'b0;
    awaited_words.push_back(w);
  endfunction

  function automatic void close_line();
    logic blank;
    blank = !line_has_ink;
    // Count the row unless it is blank and blanks are skipped; never pass the cap
    if ((!cfg_skip_blank || line_has_ink) && row_total < cfg_max_rows)
      row_total = row_total + 32'd1;
    add_word(tlsc_pkg::KIND_LINE, 8'h00, blank);
    in_record    = 1'b0;
    line_has_ink = 1'b0;
  endfunction

  function automatic void take_content(logic [7:0] b);
    in_record = 1'b1;
    if (b > tlsc_pkg::CHAR_SP)
      line_has_ink = 1'b1;
    add_word(tlsc_pkg::KIND_CONTENT, b, 1'b0);
  endfunction

  // Separator handling: LF, CR and CRLF each close one line
  function automatic void split_byte(logic [7:0] b);
    if (after_cr) begin
      after_cr = 1'b0;
      if (b == tlsc_pkg::CHAR_LF)
        return;
    end
    if (b == tlsc_pkg::CHAR_CR) begin
      after_cr = 1'b1;
      close_line();
    end else if (b == tlsc_pkg::CHAR_LF) begin
      close_line();
    end else begin
      take_content(b);
    end
  endfunction

  // Give back the held mark bytes as plain content
  function automatic void replay_mark();
    if (mark_phase == tlsc_pkg::PH_EF || mark_phase == tlsc_pkg::PH_EFBB)
      take_content(tlsc_pkg::BOM_B0);
    if (mark_phase == tlsc_pkg::PH_EFBB)
      take_content(tlsc_pkg::BOM_B1);
    mark_phase = tlsc_pkg::PH_BODY;
  endfunction

  // Work out every result of one accepted input word
  function automatic void split_and_count(logic [7:0] b, logic is_end);
    int   first;
    logic consumed;
    first    = awaited_words.size();
    consumed = 1'b0;
    if (row_total >= cfg_max_rows)
      rows_capped = 1'b1;
    if (is_end) begin
      // Close what is open unless output has stopped, then report the count
      if (!rows_capped) begin
        replay_mark();
        if (in_record)
          close_line();
      end
      add_word(tlsc_pkg::KIND_DONE, 8'h00, 1'b0);
      clear_stream();
    end else if (!rows_capped) begin
      case (mark_phase)
        tlsc_pkg::PH_START: begin
          if (cfg_strip_bom && b == tlsc_pkg::BOM_B0) begin
            mark_phase = tlsc_pkg::PH_EF;
            consumed   = 1'b1;
          end else begin
            mark_phase = tlsc_pkg::PH_BODY;
          end
        end
        tlsc_pkg::PH_EF: begin
          if (b == tlsc_pkg::BOM_B1) begin
            mark_phase = tlsc_pkg::PH_EFBB;
            consumed   = 1'b1;
          end else begin
            replay_mark();
          end
        end
        tlsc_pkg::PH_EFBB: begin
          if (b == tlsc_pkg::BOM_B2) begin
            mark_phase = tlsc_pkg::PH_BODY;
            consumed   = 1'b1;
          end else begin
            replay_mark();
          end
        end
        default: ;
      endcase
      if (!consumed)
        split_byte(b);
    end
    // Flag the final word of this run
    if (awaited_words.size() > first)
      awaited_words[awaited_words.size() - 1].last = 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Monitors
  // ---------------------------------------------------------------------------

  // Predict on every accepted input word
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready)
      split_and_count(in_ch.in_byte, in_ch.is_end);
  end

  // Track register writes
  always @(posedge clk) begin
    if (rst_n && cfg_ch.valid && cfg_ch.ready) begin
      case (cfg_ch.index)
        tlsc_pkg::REG_STRIP_BOM:  cfg_strip_bom  = cfg_ch.data[0];
        tlsc_pkg::REG_SKIP_BLANK: cfg_skip_blank = cfg_ch.data[0];
        tlsc_pkg::REG_MAX_ROWS:   cfg_max_rows   = cfg_ch.data;
        default: ;
      endcase
    end
  end

  task automatic report_mismatch(input string what);
    fail_count++;
    if (fail_count <= 50)
      $display("[%0t] MISMATCH: %s", $time, what);
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0h, want %0h", name, got, want));
  endtask

  // Compare each accepted result word with the oldest one owed
  always @(posedge clk) begin : result_check
    line_word_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (awaited_words.size() == 0) begin
        report_mismatch($sformatf("word kind %0d byte %02h with none owed",
                                  out_ch.kind, out_ch.out_byte));
      end else begin
        want = awaited_words.pop_front();
        check_field("kind",        32'(out_ch.kind),        32'(want.res.kind));
        check_field("out_byte",    32'(out_ch.out_byte),    32'(want.res.out_byte));
        check_field("line_blank",  32'(out_ch.line_blank),  32'(want.res.line_blank));
        check_field("row_count",   out_ch.row_count,        want.res.row_count);
        check_field("last_of_run", 32'(out_ch.last_of_run), 32'(want.last));
      end
    end
  end

  // Give up once no channel has moved a word for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Unless steady, half the words go back to back; the rest wait a gap drawn from 0 to STALL_MAX
  function automatic int draw_gap();
    if (steady || $urandom_range(0, 1) == 0)
      return 0;
    return $urandom_range(0, STALL_MAX);
  endfunction

  // Receiver: hold ready low for a drawn number of cycles per word.
  // Keep ready high across back-to-back words so it never toggles in one step.
  initial begin : result_taker
    int stall;
    out_ch.ready = 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (hold_rx) begin
        // Long hold-off: the block fills up and must stall its input
        hold_rx = 1'b0;
        stall   = HOLD_CYCLES;
      end else begin
        stall = draw_gap();
      end
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
    end
  end

  // Offer one input word and hold it until accepted.
  // Drop valid only when a gap follows, so valid never toggles in one step.
  task automatic send_word(input logic [7:0] b, input logic is_end);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.in_byte <= b;
    in_ch.is_end  <= is_end;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic send_end();
    logic [7:0] junk;
    junk = 8'($urandom_range(0, 255));   // byte field is don't-care on an end word
    send_word(junk, 1'b1);
  endtask

  task automatic cfg_handshake();
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
  endtask

  // Write all three registers back to back; flag words carry random upper bits
  task automatic write_regs(input logic strip, input logic skip, input logic [31:0] max);
    logic [31:0] junk;
    junk = $urandom();
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= tlsc_pkg::REG_STRIP_BOM;
    cfg_ch.data  <= {junk[31:1], strip};
    cfg_handshake();
    junk = $urandom();
    cfg_ch.index <= tlsc_pkg::REG_SKIP_BLANK;
    cfg_ch.data  <= {junk[31:1], skip};
    cfg_handshake();
    cfg_ch.index <= tlsc_pkg::REG_MAX_ROWS;
    cfg_ch.data  <= max;
    cfg_handshake();
    cfg_ch.valid <= 1'b0;
  endtask

  // Stop offering, wait for every owed result, then let the pipeline settle
  // before the next register write
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (awaited_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Text bytes: mostly printable, with blanks, high bytes and stray separators
  function automatic logic [7:0] text_byte();
    logic [7:0] b;
    case ($urandom_range(0, 9))
      0:       b = tlsc_pkg::CHAR_CR;
      1:       b = tlsc_pkg::CHAR_LF;
      2:       b = 8'($urandom_range(8'h00, 8'h20));
      3:       b = 8'($urandom_range(8'h80, 8'hff));
      default: b = 8'($urandom_range(8'h21, 8'h7e));
    endcase
    return b;
  endfunction

  // One stream: optional (possibly broken) mark, lines with mixed separators,
  // an open tail now and then, and usually an end word. Some streams are noise.
  task automatic send_stream(output int n);
    int lines;
    n = 0;
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 12)) begin
        send_word(8'($urandom_range(0, 255)), 1'b0);
        n++;
      end
    end else begin
      case ($urandom_range(0, 5))
        0: begin
          send_word(tlsc_pkg::BOM_B0, 1'b0);
          send_word(tlsc_pkg::BOM_B1, 1'b0);
          send_word(tlsc_pkg::BOM_B2, 1'b0);
          n += 3;
        end
        1: begin
          send_word(tlsc_pkg::BOM_B0, 1'b0);
          n++;
        end
        2: begin
          send_word(tlsc_pkg::BOM_B0, 1'b0);
          send_word(tlsc_pkg::BOM_B1, 1'b0);
          n += 2;
        end
        default: ;
      endcase
      lines = $urandom_range(0, 4);
      repeat (lines) begin
        repeat ($urandom_range(0, 6)) begin
          send_word(text_byte(), 1'b0);
          n++;
        end
        case ($urandom_range(0, 3))
          0: begin
            send_word(tlsc_pkg::CHAR_LF, 1'b0);
            n++;
          end
          1: begin
            send_word(tlsc_pkg::CHAR_CR, 1'b0);
            n++;
          end
          2: begin
            send_word(tlsc_pkg::CHAR_CR, 1'b0);
            send_word(tlsc_pkg::CHAR_LF, 1'b0);
            n += 2;
          end
          default: begin
            send_word(tlsc_pkg::CHAR_LF, 1'b0);
            send_word(tlsc_pkg::CHAR_CR, 1'b0);
            n += 2;
          end
        endcase
      end
      if ($urandom_range(0, 1) == 1) begin
        repeat ($urandom_range(1, 4)) begin
          send_word(text_byte(), 1'b0);
          n++;
        end
      end
    end
    // Leave a stream unterminated now and then; state carries into the next
    if ($urandom_range(0, 11) != 0) begin
      send_end();
      n++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Full mark dropped, CRLF as one line end; a broken mark replayed; an end
  // while a partial mark is held closes the replayed record
  task automatic test_mark_strip();
    write_regs(1'b1, 1'b0, 32'hffff_ffff);
    send_word(tlsc_pkg::BOM_B0, 1'b0);
    send_word(tlsc_pkg::BOM_B1, 1'b0);
    send_word(tlsc_pkg::BOM_B2, 1'b0);
    send_word(8'h41, 1'b0);
    send_word(tlsc_pkg::CHAR_CR, 1'b0);
    send_word(tlsc_pkg::CHAR_LF, 1'b0);
    send_end();
    send_word(tlsc_pkg::BOM_B0, 1'b0);
    send_word(8'h78, 1'b0);
    send_end();
    send_word(tlsc_pkg::BOM_B0, 1'b0);
    send_word(tlsc_pkg::BOM_B1, 1'b0);
    send_end();
    drain_results();
  endtask

  // A match under way finishes even when mark stripping is switched off
  task automatic test_mark_switch_off();
    send_word(tlsc_pkg::BOM_B0, 1'b0);
    drain_results();
    write_regs(1'b0, 1'b0, 32'hffff_ffff);
    send_word(tlsc_pkg::BOM_B1, 1'b0);
    send_word(tlsc_pkg::BOM_B2, 1'b0);
    send_word(tlsc_pkg::CHAR_LF, 1'b0);
    send_end();
    drain_results();
  endtask

  // Skipped blank line, then the cap stops output and the end gives done only
  task automatic test_blank_limit();
    write_regs(1'b0, 1'b1, 32'd1);
    send_word(tlsc_pkg::CHAR_SP, 1'b0);
    send_word(tlsc_pkg::CHAR_LF, 1'b0);
    send_word(8'hff, 1'b0);
    send_word(tlsc_pkg::CHAR_CR, 1'b0);
    send_word(8'h00, 1'b0);
    send_end();
    drain_results();
  endtask

  // Blank open record closed and counted at the end; then max_rows lowered
  // to the running count mid-stream
  task automatic test_lowered_cap();
    write_regs(1'b0, 1'b0, 32'hffff_ffff);
    send_word(tlsc_pkg::CHAR_SP, 1'b0);
    send_end();
    send_word(8'h61, 1'b0);
    send_word(tlsc_pkg::CHAR_LF, 1'b0);
    drain_results();
    write_regs(1'b0, 1'b0, 32'd1);
    send_word(8'h63, 1'b0);
    send_end();
    drain_results();
  endtask

  // Random streams in eight phases of register settings, caps at both extremes
  task automatic test_random_streams();
    int          sent;
    int          n;
    int          phase_items[8] = '{25, 10, 25, 25, 25, 25, 25, 25};
    logic [31:0] phase_max[8]   = '{32'hffff_ffff, 32'h0, 32'd3, 32'hffff_ffff,
                                    32'd1, 32'd4, 32'h8000_0000, 32'hffff_ffff};
    phase_max[5] = $urandom_range(2, 6);
    for (int p = 0; p < 8; p++) begin
      write_regs(p[0], p[1], phase_max[p]);
      steady = (p == 5);   // one stretch with no idling on either side
      sent = 0;
      while (sent < phase_items[p]) begin
        send_stream(n);
        sent += n;
      end
      drain_results();
    end
    steady = 1'b0;
  endtask

  // Receiver holds off for a long stretch while the sender keeps offering
  task automatic test_backpressure();
    int sent;
    int n;
    write_regs(1'b1, 1'b0, 32'hffff_ffff);
    steady  = 1'b1;
    hold_rx = 1'b1;
    sent = 0;
    while (sent < PRESSURE_ITEMS) begin
      send_stream(n);
      sent += n;
    end
    steady = 1'b0;
    drain_results();
  endtask

  initial begin
    // Every input known from time zero
    in_ch.valid   = 1'b0;
    in_ch.in_byte = 8'h00;
    in_ch.is_end  = 1'b0;
    cfg_ch.valid  = 1'b0;
    cfg_ch.index  = tlsc_pkg::REG_STRIP_BOM;
    cfg_ch.data   = '0;
    rst_n         = 1'b0;
    cfg_strip_bom  = 1'b0;
    cfg_skip_blank = 1'b0;
    cfg_max_rows   = '1;
    clear_stream();

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_mark_strip();
    test_mark_switch_off();
    test_blank_limit();
    test_lowered_cap();
    test_random_streams();
    test_backpressure();

    if (fail_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
